FILE: hdl/ffsa_pkg.sv
// Package for the first-fit segment allocator: pool sizing, field widths,
// status and job-kind codes, and the request, response and job structs.
// Used by every module of the block.
package ffsa_pkg;

  localparam int MEM_UNITS = 16;
  localparam int OWNERS    = 8;

  localparam int UNIT_W   = $clog2(MEM_UNITS);
  localparam int CNT_W    = $clog2(MEM_UNITS + 1);
  localparam int OWN_W    = 3;
  localparam int SIZE_W   = 5;
  localparam int STATUS_W = 2;
  localparam int START_W  = 4;
  localparam int REL_W    = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 2'd3;

  localparam logic [1:0] KIND_ALLOC      = 2'd0;
  localparam logic [1:0] KIND_FREE       = 2'd1;
  localparam logic [1:0] KIND_REJ_ALLOC  = 2'd2;
  localparam logic [1:0] KIND_REJ_FREE   = 2'd3;

  typedef struct packed {
    logic              command;
    logic [OWN_W-1:0]  owner;
    logic [SIZE_W-1:0] request_size;
  } ffsa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_index;
    logic [REL_W-1:0]    units_released;
  } ffsa_rsp_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OWN_W-1:0] owner;
    logic [CNT_W-1:0] len;
  } ffsa_job_t;

endpackage

FILE: hdl/first_fit_segment_allocator_top.sv
// First-fit segment allocator over MEM_UNITS units with per-unit owner map.
// Rejected requests are answered without a scan; an allocate scans the map from unit 0
// until a run of free units completes the first fit or the map ends; a free scans the
// whole map. The back end takes a new job only once the last response has been
// accepted, and its scan of the map takes one unit per cycle.
// Reset: every unit free, queue and response register empty.
module first_fit_segment_allocator_top import ffsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ffsa_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ffsa_rsp_t rsp
);

  logic      job_valid;
  logic      job_pop;
  ffsa_job_t job;

  ffsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  ffsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_grant_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_GRANTED |-> rsp.units_released == '0)
    else $error("grant carries released units");

  a_nofit_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NOFIT |-> rsp.start_index == '0 && rsp.units_released == '0)
    else $error("no-fit response carries nonzero fields");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.status == ST_FREED) == (rsp.units_released != '0)))
    else $error("freed status disagrees with released count");

endmodule

FILE: hdl/ffsa_front.sv
// Front end: accepts requests, classifies them into jobs and holds them in a
// two-entry queue for the back end. Depends on ffsa_pkg.
module ffsa_front import ffsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ffsa_req_t req,
  output logic      job_valid,
  output ffsa_job_t job,
  input  logic      job_pop
);

  ffsa_job_t  q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  ffsa_job_t  job_in;
  logic       push;
  logic       owner_ok;
  logic       size_ok;

  assign owner_ok = 32'(req.owner) < OWNERS;
  assign size_ok  = (req.request_size != '0) && (32'(req.request_size) <= MEM_UNITS);

  always_comb begin
    job_in.owner = req.owner;
    job_in.len   = CNT_W'(req.request_size);
    if (req.command == CMD_FREE) begin
      job_in.kind = owner_ok ? KIND_FREE : KIND_REJ_FREE;
    end else begin
      job_in.kind = (owner_ok && size_ok) ? KIND_ALLOC : KIND_REJ_ALLOC;
    end
  end

  assign req_ready = (count != 2'd2);
  assign push      = req_valid && req_ready;
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(job_pop);
    end
  end

endmodule

FILE: hdl/ffsa_back.sv
// Back end: owns the unit map; scans it a unit per cycle per alloc/free job
// (rejects skip it); posts responses in an output register. Uses ffsa_pkg.
module ffsa_back import ffsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  ffsa_job_t job,
  output logic      job_pop,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ffsa_rsp_t rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state;
  ffsa_job_t            cur;
  logic [UNIT_W-1:0]    idx;
  logic [CNT_W-1:0]     run;
  logic [CNT_W-1:0]     released;
  logic [MEM_UNITS-1:0] busy;
  logic [OWN_W-1:0]     owner_map [MEM_UNITS];

  logic                 cur_busy;
  logic [CNT_W-1:0]     run_next;
  logic [CNT_W-1:0]     rel_next;
  logic                 fit;
  logic                 hit;
  logic                 last;
  logic                 grant;
  logic [UNIT_W-1:0]    start_calc;
  logic [MEM_UNITS-1:0] grant_mask;

  assign cur_busy   = busy[idx];
  assign run_next   = cur_busy ? '0 : run + CNT_W'(1);
  assign fit        = !cur_busy && (run_next >= cur.len);
  assign hit        = cur_busy && (owner_map[idx] == cur.owner);
  assign rel_next   = released + CNT_W'(hit);
  assign last       = (idx == UNIT_W'(MEM_UNITS - 1));
  assign start_calc = UNIT_W'(CNT_W'(idx) + CNT_W'(1) - cur.len);
  assign grant      = (state == S_SCAN) && (cur.kind == KIND_ALLOC) && fit;
  assign job_pop    = (state == S_IDLE) && job_valid && !rsp_valid;

  always_comb begin
    for (int i = 0; i < MEM_UNITS; i++) begin
      grant_mask[i] = grant && (UNIT_W'(i) >= start_calc) && (UNIT_W'(i) <= idx);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MEM_UNITS; i++) begin
      if (grant_mask[i]) begin
        owner_map[i] <= cur.owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= '0;
      rsp_valid <= 1'b0;
      idx       <= '0;
      run       <= '0;
      released  <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_pop) begin
            idx      <= '0;
            run      <= '0;
            released <= '0;
            if (job.kind == KIND_REJ_ALLOC || job.kind == KIND_REJ_FREE) begin
              rsp_valid          <= 1'b1;
              rsp.status         <= (job.kind == KIND_REJ_ALLOC) ? ST_NOFIT : ST_NOTHING;
              rsp.start_index    <= '0;
              rsp.units_released <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cur.kind == KIND_ALLOC) begin
            run <= run_next;
            if (fit) begin
              busy               <= busy | grant_mask;
              rsp_valid          <= 1'b1;
              rsp.status         <= ST_GRANTED;
              rsp.start_index    <= START_W'(start_calc);
              rsp.units_released <= '0;
              state              <= S_IDLE;
            end else if (last) begin
              rsp_valid          <= 1'b1;
              rsp.status         <= ST_NOFIT;
              rsp.start_index    <= '0;
              rsp.units_released <= '0;
              state              <= S_IDLE;
            end else begin
              idx <= idx + UNIT_W'(1);
            end
          end else begin
            released <= rel_next;
            if (hit) begin
              busy[idx] <= 1'b0;
            end
            if (last) begin
              rsp_valid          <= 1'b1;
              rsp.status         <= (rel_next != '0) ? ST_FREED : ST_NOTHING;
              rsp.start_index    <= '0;
              rsp.units_released <= REL_W'(rel_next);
              state              <= S_IDLE;
            end else begin
              idx <= idx + UNIT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
